@@ sv/shmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmc_pkg
// Shared types and constants for the shadow memory heap checker.
// ----------------------------------------------------------------------------
package shmc_pkg;

    // Store geometry
    localparam int SHADOW_GRANULES = 65536;
    localparam int MAX_ACCESS      = 64;
    localparam int GIDX_W          = $clog2(SHADOW_GRANULES);
    localparam int GRAN_W          = 30;                       // addr>>3 plus carry
    localparam int CNT_W           = 21;                       // length>>3
    localparam int LEFT_W          = $clog2(MAX_ACCESS + 1);
    localparam int STEP_W          = 3;

    // Shadow byte encodings
    localparam logic [7:0] MARK_LEFT  = 8'hf3;
    localparam logic [7:0] MARK_RIGHT = 8'hf4;
    localparam logic [7:0] MARK_FREED = 8'h08;
    localparam logic [7:0] MARK_ZONE  = 8'h80;
    localparam logic [2:0] SUB_MASK   = 3'h7;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        FND_NONE      = 3'd0,
        FND_UNDERFLOW = 3'd1,
        FND_UNDERRUN  = 3'd2,
        FND_OVERFLOW  = 3'd3,
        FND_OVERRUN   = 3'd4,
        FND_OOB       = 3'd5,
        FND_UAF       = 3'd6,
        FND_RSVD      = 3'd7
    } t_finding;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
        logic [23:0] length;
        logic        write_access;
        logic [31:0] instruction_address;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  finding;
        logic [31:0] byte_address;
        logic [31:0] reporting_instruction;
        logic        last;
    } t_out_word;

    // Controller -> datapath
    typedef struct packed {
        logic              load_item;
        logic              step_load;
        logic [STEP_W-1:0] step;
        logic              fill_write;
        logic              clr_write;
        logic              acc_read;
        logic              acc_emit;
    } t_ctrl_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_op  in_op;
        logic in_len_zero;
        logic step_en;
        logic step_last;
        logic fill_done;
        logic clr_done;
        logic acc_last;
        logic gran_end;
        logic out_free;
    } t_dp_sts;

endpackage

@@ sv/shmc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmc_ctrl
// Sequencer: store clear, alloc/free step walk, per-byte access checks.
// ----------------------------------------------------------------------------
module shmc_ctrl
    import shmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_sts   i_sts,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_STEP     = 6'b000100,
        S_FILL     = 6'b001000,
        S_ACC_RD   = 6'b010000,
        S_ACC_EMIT = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_cmd           = '0;
        o_cmd.step      = r_step;
        o_in_ready      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    unique case (i_sts.in_op)
                        OP_ACCESS: n_state = i_sts.in_len_zero ? S_IDLE : S_ACC_RD;
                        OP_ALLOC, OP_FREE: begin
                            n_state = S_STEP;
                            n_step  = '0;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_STEP: begin
                if (i_sts.step_en) begin
                    o_cmd.step_load = 1'b1;
                    n_state         = S_FILL;
                end else if (i_sts.step_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FILL: begin
                o_cmd.fill_write = 1'b1;
                if (i_sts.fill_done) begin
                    if (i_sts.step_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = S_STEP;
                    end
                end
            end
            S_ACC_RD: begin
                o_cmd.acc_read = 1'b1;
                n_state        = S_ACC_EMIT;
            end
            S_ACC_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.acc_emit = 1'b1;
                    if (i_sts.acc_last) begin
                        n_state = S_IDLE;
                    end else if (i_sts.gran_end) begin
                        n_state = S_ACC_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

@@ sv/shmc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmc_dp
// Datapath: shadow store, item registers, granule fill engine, byte checker
// and output register.
// ----------------------------------------------------------------------------
module shmc_dp
    import shmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  t_ctrl_cmd i_cmd,
    output t_dp_sts   o_sts
);

    // Step numbers of the alloc and free sequences
    localparam logic [STEP_W-1:0] ST_A_BODY_HEAD  = 3'd0;
    localparam logic [STEP_W-1:0] ST_A_BODY       = 3'd1;
    localparam logic [STEP_W-1:0] ST_A_LEFT_HEAD  = 3'd2;
    localparam logic [STEP_W-1:0] ST_A_LEFT       = 3'd3;
    localparam logic [STEP_W-1:0] ST_A_RIGHT_HEAD = 3'd4;
    localparam logic [STEP_W-1:0] ST_A_RIGHT      = 3'd5;
    localparam logic [STEP_W-1:0] ST_F_BODY       = 3'd0;
    localparam logic [STEP_W-1:0] ST_F_TAIL       = 3'd1;
    localparam logic [STEP_W-1:0] ST_F_LEFT       = 3'd2;
    localparam logic [STEP_W-1:0] ST_F_END_HEAD   = 3'd3;
    localparam logic [STEP_W-1:0] ST_F_END        = 3'd4;

    localparam logic [GRAN_W-1:0] GRAN_LIMIT = GRAN_W'(SHADOW_GRANULES);
    localparam logic [GRAN_W-1:0] GRAN_TOP   = GRAN_W'(SHADOW_GRANULES - 1);
    localparam logic [LEFT_W-1:0] ACC_MAX    = LEFT_W'(MAX_ACCESS);

    logic [7:0] mem [SHADOW_GRANULES];
    logic [7:0] r_rd_data;

    // Item registers
    t_op               r_op;
    logic [31:0]       r_addr;
    logic [23:0]       r_len;
    logic              r_wr;
    logic [31:0]       r_ia;
    logic [LEFT_W-1:0] r_left;

    // Fill engine
    logic [GRAN_W-1:0] r_fg;
    logic [CNT_W-1:0]  r_fn;
    logic [7:0]        r_fv;

    logic      r_out_valid;
    t_out_word r_out;

    // Region geometry of the latched item
    logic [GRAN_W-1:0] g, g_in, gl, gl_in, eg, eg_in, g_tail;
    logic [2:0]        off, rem, eoff;
    logic [CNT_W-1:0]  n, n1;
    logic [31:0]       end_addr;
    logic [GRAN_W-1:0] step_gran;
    logic [CNT_W-1:0]  step_cnt;
    logic [7:0]        step_val;
    logic              step_en;

    logic              fill_in_store;
    logic [GRAN_W-1:0] acc_gran;
    logic              acc_in_store;
    logic              out_free;

    always_comb begin
        off      = r_addr[2:0] & SUB_MASK;
        rem      = r_len[2:0];
        n        = r_len[23:3];
        n1       = (n == '0) ? CNT_W'(1) : n;
        g        = {1'b0, r_addr[31:3]};
        gl       = {1'b0, r_addr[31:3] - 29'd1};
        end_addr = r_addr + {8'd0, r_len};
        eg       = {1'b0, end_addr[31:3]};
        eoff     = end_addr[2:0];
        g_in     = g + GRAN_W'(off != 3'd0);
        gl_in    = gl + GRAN_W'(off != 3'd0);
        eg_in    = eg + GRAN_W'(eoff != 3'd0);
        g_tail   = g + GRAN_W'(n);
    end

    // Step table: start granule, granule count, value, taken
    always_comb begin
        step_gran = g;
        step_cnt  = CNT_W'(1);
        step_val  = 8'h00;
        step_en   = 1'b1;
        if (r_op == OP_ALLOC) begin
            unique case (i_cmd.step)
                ST_A_BODY_HEAD: begin
                    step_val = {5'd0, off};
                    step_en  = (off != 3'd0);
                end
                ST_A_BODY: begin
                    step_gran = g_in;
                    step_cnt  = n1;
                end
                ST_A_LEFT_HEAD: begin
                    step_gran = gl;
                    step_val  = {5'd0, off};
                    step_en   = (off != 3'd0);
                end
                ST_A_LEFT: begin
                    step_gran = gl_in;
                    step_val  = MARK_LEFT;
                end
                ST_A_RIGHT_HEAD: begin
                    step_gran = eg;
                    step_val  = {5'd0, eoff};
                    step_en   = (eoff != 3'd0);
                end
                ST_A_RIGHT: begin
                    step_gran = eg_in;
                    step_val  = MARK_RIGHT;
                end
                default: step_en = 1'b0;
            endcase
        end else begin
            unique case (i_cmd.step)
                ST_F_BODY: begin
                    step_cnt = n1;
                    step_val = MARK_FREED;
                end
                ST_F_TAIL: begin
                    step_gran = g_tail;
                    step_val  = {5'd0, rem} | MARK_FREED;
                    step_en   = (rem != 3'd0);
                end
                ST_F_LEFT: begin
                    step_gran = gl;
                end
                ST_F_END_HEAD: begin
                    step_gran = eg;
                    step_val  = {5'd0, eoff} | MARK_FREED;
                    step_en   = (eoff != 3'd0);
                end
                ST_F_END: begin
                    step_gran = eg_in;
                end
                default: step_en = 1'b0;
            endcase
        end
    end

    function automatic logic [2:0] classify(input logic [7:0] s, input logic [2:0] o,
                                            input logic wr, input logic in_store);
        logic [7:0] tail;
        logic [2:0] f;
        tail = s ^ MARK_FREED;
        f    = FND_NONE;
        if (!in_store || s == 8'h00) begin
            f = FND_NONE;
        end else if ((s & MARK_ZONE) != 8'h00) begin
            if (s == MARK_LEFT) begin
                f = wr ? FND_UNDERFLOW : FND_UNDERRUN;
            end else if (s == MARK_RIGHT) begin
                f = wr ? FND_OVERFLOW : FND_OVERRUN;
            end else begin
                f = FND_OOB;
            end
        end else if ((s & MARK_FREED) != 8'h00) begin
            if (s == MARK_FREED || {5'd0, o} < tail) begin
                f = FND_UAF;
            end
        end else if ({5'd0, o} >= s) begin
            f = wr ? FND_OVERFLOW : FND_OVERRUN;
        end
        return f;
    endfunction

    assign fill_in_store = (r_fg < GRAN_LIMIT);
    assign acc_gran      = {1'b0, r_addr[31:3]};
    assign acc_in_store  = (acc_gran < GRAN_LIMIT);
    assign out_free      = !r_out_valid || i_out_ready;

    // Shadow store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_write) begin
            mem[r_fg[GIDX_W-1:0]] <= 8'h00;
        end else if (i_cmd.fill_write && fill_in_store) begin
            mem[r_fg[GIDX_W-1:0]] <= r_fv;
        end
        if (i_cmd.acc_read) begin
            r_rd_data <= mem[acc_gran[GIDX_W-1:0]];
        end
    end

    // Item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= t_op'(i_in_word.command);
            r_addr <= i_in_word.address;
            r_len  <= i_in_word.length;
            r_wr   <= i_in_word.write_access;
            r_ia   <= i_in_word.instruction_address;
            r_left <= (i_in_word.length > 24'(MAX_ACCESS)) ? ACC_MAX
                                                           : i_in_word.length[LEFT_W-1:0];
        end else if (i_cmd.acc_emit) begin
            r_addr <= r_addr + 32'd1;
            r_left <= r_left - 1'b1;
        end
    end

    // Fill engine; granule pointer doubles as the clear sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= '0;
        end else if (i_cmd.step_load) begin
            r_fg <= step_gran;
        end else if (i_cmd.fill_write || i_cmd.clr_write) begin
            r_fg <= r_fg + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_load) begin
            r_fn <= step_cnt;
            r_fv <= step_val;
        end else if (i_cmd.fill_write) begin
            r_fn <= r_fn - 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.acc_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_emit) begin
            r_out.finding               <= classify(r_rd_data, r_addr[2:0], r_wr,
                                                    acc_in_store);
            r_out.byte_address          <= r_addr;
            r_out.reporting_instruction <= r_ia;
            r_out.last                  <= (r_left == LEFT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        o_sts             = '0;
        o_sts.in_op       = t_op'(i_in_word.command);
        o_sts.in_len_zero = (i_in_word.length == 24'd0);
        o_sts.step_en     = step_en;
        o_sts.step_last   = (r_op == OP_ALLOC) ? (i_cmd.step == ST_A_RIGHT)
                                               : (i_cmd.step == ST_F_END);
        o_sts.fill_done   = (r_fn == CNT_W'(1)) || !fill_in_store;
        o_sts.clr_done    = (r_fg == GRAN_TOP);
        o_sts.acc_last    = (r_left == LEFT_W'(1));
        o_sts.gran_end    = (r_addr[2:0] == SUB_MASK);
        o_sts.out_free    = out_free;
    end

endmodule

@@ sv/shadow_memory_heap_checker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_memory_heap_checker_core
// Heap checker keeping one shadow byte per 8-byte granule of address space.
// ----------------------------------------------------------------------------
// After reset the block sweeps the shadow store to zero (every granule
// addressable), one granule per clock over all SHADOW_GRANULES (65536)
// granules, with o_in_ready low. Each input word is one command. Alloc marks
// the block body addressable with a left redzone 0xf3 and a right redzone
// 0xf4; free marks the body freed (0x08, or 0x08 | tail byte count) and
// clears both redzones. Neither returns a result word. Alloc and free run as
// a walk of up to six region steps through one granule write port: each step
// is examined in turn and, if taken, writes its granules one after another.
// The body step covers length/8 granules (at least one), and a granule past
// the store ends its step without a write.
// An access returns one result word per byte, up to MAX_ACCESS (64) bytes,
// with last set on the final one; a zero-length access or command 3 returns
// nothing. An access reads the store once per granule touched, and each byte
// waits until the result register is free before its word is emitted.
// Bytes whose granule lies beyond the store report no finding. The result
// register lets a new command be accepted while the last word still waits.
// ----------------------------------------------------------------------------
module shadow_memory_heap_checker_core
    import shmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // Command and status between sequencer and datapath
    t_ctrl_cmd ctrl_cmd;
    t_dp_sts   dp_sts;

    // Sequencer: clear sweep, alloc/free step walk, access byte loop
    shmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (ctrl_cmd)
    );

    // Shadow store, fill engine, byte classifier, result register
    shmc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cmd       (ctrl_cmd),
        .o_sts       (dp_sts)
    );

endmodule
